/* src/cascaded_window_statistics_assert.svh */
// Assertion helpers shared by the RTL.
`ifndef CASCADED_WINDOW_STATISTICS_ASSERT_SVH
`define CASCADED_WINDOW_STATISTICS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cws_pkg.sv */
package cws_pkg;

    // Ring positions and scan indexes cover rings of up to 64 slots.
    localparam int POS_W = 6;

    typedef struct packed {
        logic [63:0] cnt;
        logic [63:0] sum;
        logic [63:0] peak;
    } t_agg;

    typedef struct packed {
        logic [31:0] tick_count;
        logic [63:0] tick_sum;
        logic [63:0] tick_peak;
    } t_item;

    typedef struct packed {
        logic [63:0] short_avg;
        logic [63:0] short_peak;
        logic [63:0] mid_avg;
        logic [63:0] mid_peak;
        logic [63:0] long_avg;
        logic [63:0] long_peak;
        logic [63:0] all_avg;
        logic [63:0] all_peak;
    } t_result;

endpackage

/* src/cws_stream_if.sv */
interface cws_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/cws_ring_mem.sv */
module cws_ring_mem #(
    parameter int SLOTS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [cws_pkg::POS_W-1:0] i_waddr,
    input  cws_pkg::t_agg             i_wdata,
    input  logic [cws_pkg::POS_W-1:0] i_raddr,
    output cws_pkg::t_agg             o_rdata
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cws_pkg::t_agg r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    cws_pkg::t_agg r_rd;
    logic r_rd_vld;

    // Slots never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr[AW-1:0]] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr[AW-1:0]];
    end

    assign o_rdata = r_rd_vld ? r_rd : '0;
endmodule

/* src/cws_div.sv */
module cws_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic        r_done;
    logic [64:0] w_shift;
    logic [64:0] w_diff;

    // Restoring division, one quotient bit per cycle.
    assign w_shift = {r_rem, r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_shift[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* src/cascaded_window_statistics.sv */
// Channel | Dir | Payload                                   | Transfer
// i_in    | in  | tick_count, tick_sum, tick_peak           | valid && ready
// o_out   | out | avg and peak of short, mid, long, all     | valid && ready
//
// An item starts at the short ring; when a ring wraps, its total is pushed into the next ring.
// A ring push reads and updates a slot, then advances; a possibly evicted peak forces a rescan.
// The four averages share one bit-serial divider; each average holds the sequencer until it is done.
// Reset is synchronous and active low; it clears all totals and slot valid bits.
// The input is not ready while an item is in work or its result waits.
`include "cascaded_window_statistics_assert.svh"

module cascaded_window_statistics #(
    parameter int SHORT_SLOTS = 10,
    parameter int MID_SLOTS   = 60,
    parameter int LONG_SLOTS  = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cws_stream_if.sink   i_in,
    cws_stream_if.source o_out
);
    localparam int PW = cws_pkg::POS_W;
    localparam logic [PW-1:0] LAST_S = PW'(SHORT_SLOTS - 1);
    localparam logic [PW-1:0] LAST_M = PW'(MID_SLOTS - 1);
    localparam logic [PW-1:0] LAST_L = PW'(LONG_SLOTS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_UPD   = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_NEXT  = 8'b0001_0000,
        S_MERGE = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_DIV   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic [1:0] r_ring;
    logic [PW-1:0] r_pos [3];
    logic [PW-1:0] r_scan;
    logic r_scan_done;
    logic r_scan_v;
    cws_pkg::t_agg r_tot [3];
    cws_pkg::t_agg r_part [3];
    cws_pkg::t_agg r_grand;
    cws_pkg::t_agg r_in;
    cws_pkg::t_agg r_w;
    logic [1:0] r_win;
    logic [1:0] r_j;
    cws_pkg::t_result r_res;
    logic r_div_start;

    cws_pkg::t_agg w_rd [3];
    cws_pkg::t_agg w_old;
    cws_pkg::t_agg w_base;
    logic [PW-1:0] w_last;
    logic [PW-1:0] w_raddr;
    logic [2:0] w_we;
    logic w_div_done;
    logic [63:0] w_quo;
    logic [63:0] w_avg;
    logic [63:0] w_scan_pk;

    function automatic cws_pkg::t_agg f_merge(cws_pkg::t_agg a, cws_pkg::t_agg b);
        cws_pkg::t_agg m;
        m.cnt  = a.cnt + b.cnt;
        m.sum  = a.sum + b.sum;
        m.peak = (a.peak < b.peak) ? b.peak : a.peak;
        return m;
    endfunction

    assign w_raddr = (r_state == S_SCAN) ? r_scan : r_pos[r_ring];
    assign w_we[0] = (r_state == S_UPD) && (r_ring == 2'd0);
    assign w_we[1] = (r_state == S_UPD) && (r_ring == 2'd1);
    assign w_we[2] = (r_state == S_UPD) && (r_ring == 2'd2);

    cws_ring_mem #(.SLOTS(SHORT_SLOTS)) u_short (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_we[0]), .i_waddr(r_pos[r_ring]),
        .i_wdata(r_in), .i_raddr(w_raddr), .o_rdata(w_rd[0])
    );
    cws_ring_mem #(.SLOTS(MID_SLOTS)) u_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_we[1]), .i_waddr(r_pos[r_ring]),
        .i_wdata(r_in), .i_raddr(w_raddr), .o_rdata(w_rd[1])
    );
    cws_ring_mem #(.SLOTS(LONG_SLOTS)) u_long (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_we[2]), .i_waddr(r_pos[r_ring]),
        .i_wdata(r_in), .i_raddr(w_raddr), .o_rdata(w_rd[2])
    );

    cws_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_w.sum), .i_den(r_w.cnt), .o_done(w_div_done), .o_quo(w_quo)
    );

    always_comb begin
        case (r_ring)
            2'd0:    begin w_old = w_rd[0]; w_last = LAST_S; end
            2'd1:    begin w_old = w_rd[1]; w_last = LAST_M; end
            default: begin w_old = w_rd[2]; w_last = LAST_L; end
        endcase
        case (r_win)
            2'd0:    w_base = r_tot[0];
            2'd1:    w_base = r_tot[1];
            2'd2:    w_base = r_tot[2];
            default: w_base = r_grand;
        endcase
        w_avg = (r_w.cnt == 64'd0) ? 64'd0 : w_quo;
        w_scan_pk = (r_tot[r_ring].peak < w_old.peak) ? w_old.peak : r_tot[r_ring].peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_vld   <= 1'b0;
            r_ring      <= '0;
            r_pos       <= '{default: '0};
            r_tot       <= '{default: '0};
            r_part      <= '{default: '0};
            r_grand     <= '0;
            r_scan      <= '0;
            r_scan_done <= 1'b0;
            r_scan_v    <= 1'b0;
            r_win       <= '0;
            r_j         <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_out.valid && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && !r_out_vld) begin
                        r_in.cnt  <= 64'(i_in.data.tick_count);
                        r_in.sum  <= i_in.data.tick_sum;
                        r_in.peak <= i_in.data.tick_peak;
                        r_ring    <= 2'd0;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_part[r_ring]     <= f_merge(r_part[r_ring], r_in);
                    r_tot[r_ring].cnt  <= r_tot[r_ring].cnt + (r_in.cnt - w_old.cnt);
                    r_tot[r_ring].sum  <= r_tot[r_ring].sum + (r_in.sum - w_old.sum);
                    r_state <= S_NEXT;
                    if (r_tot[r_ring].peak < r_in.peak) begin
                        r_tot[r_ring].peak <= r_in.peak;
                    end else if (r_tot[r_ring].peak == w_old.peak) begin
                        // The evicted slot may have held the peak: rescan the ring.
                        r_tot[r_ring].peak <= '0;
                        r_scan      <= '0;
                        r_scan_done <= 1'b0;
                        r_scan_v    <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_scan_v <= !r_scan_done;
                    if (!r_scan_done) begin
                        if (r_scan == w_last) begin
                            r_scan_done <= 1'b1;
                        end else begin
                            r_scan <= r_scan + PW'(1);
                        end
                    end
                    if (r_scan_v) begin
                        r_tot[r_ring].peak <= w_scan_pk;
                    end
                    if (r_scan_v && r_scan_done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_pos[r_ring] == w_last) begin
                        r_pos[r_ring]  <= '0;
                        r_part[r_ring] <= '0;
                        if (r_ring == 2'd2) begin
                            r_grand <= f_merge(r_grand, r_tot[2]);
                            r_win   <= '0;
                            r_state <= S_MERGE;
                        end else begin
                            r_in    <= r_tot[r_ring];
                            r_ring  <= r_ring + 2'd1;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_pos[r_ring] <= r_pos[r_ring] + PW'(1);
                        r_win   <= '0;
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    r_w     <= w_base;
                    r_j     <= r_win;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // Fold in the partials of every shorter ring, one per cycle.
                    if (r_j != 2'd0) begin
                        r_w <= f_merge(r_w, r_part[r_j - 2'd1]);
                        r_j <= r_j - 2'd1;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        case (r_win)
                            2'd0: begin
                                r_res.short_avg  <= w_avg;
                                r_res.short_peak <= r_w.peak;
                            end
                            2'd1: begin
                                r_res.mid_avg  <= w_avg;
                                r_res.mid_peak <= r_w.peak;
                            end
                            2'd2: begin
                                r_res.long_avg  <= w_avg;
                                r_res.long_peak <= r_w.peak;
                            end
                            default: begin
                                r_res.all_avg  <= w_avg;
                                r_res.all_peak <= r_w.peak;
                            end
                        endcase
                        if (r_win == 2'd3) begin
                            r_out_vld <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_win   <= r_win + 2'd1;
                            r_state <= S_MERGE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE) && !r_out_vld;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_res;

    `CWS_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, i_in.ready, !o_out.valid,
        "input ready while a result is pending")
    `CWS_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == S_READ && r_ring == 2'd0, "accepted item did not start at the short ring")
    `CWS_ASSERT_SAME(a_pos_range, i_clk, i_rst_n, 1'b1,
        r_pos[0] <= LAST_S && r_pos[1] <= LAST_M && r_pos[2] <= LAST_L,
        "ring position beyond its ring")
    `CWS_ASSERT_NEXT(a_result_after_div, i_clk, i_rst_n,
        r_state == S_DIV && w_div_done && r_win == 2'd3, o_out.valid,
        "result not raised after the last division")
endmodule
